FILE: sv/ccpt_pkg.sv
// Package for the color class partition table.
// Holds command and status codes and field widths; no dependencies.
package ccpt_pkg;

    localparam int MAX_VERTICES_DEF = 256;
    localparam int VTX_W = 8;
    localparam int CMD_W = 3;
    localparam int STAT_W = 2;
    localparam int TOT_W = 9;

    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_OPEN = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RD_MEMBER = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RD_START = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

endpackage

FILE: sv/ccpt_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Used for the member store and the class start table; no dependencies.
module ccpt_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH = 256
) (
    input  logic                      aclk,
    input  logic                      we,
    input  logic [$clog2(DEPTH)-1:0]  waddr,
    input  logic [DATA_W-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0]  raddr,
    output logic [DATA_W-1:0]         rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/color_class_partition_table.sv
// Color class partition table top level: command sequencer over two RAMs.
// Depends on ccpt_pkg and ccpt_ram.
//
// Vertices sit packed in a member RAM, grouped into contiguous classes whose
// start offsets live in a second RAM. One request is taken at a time and
// gives one result; s_ready is high only while no request is in work, but
// a finished result may wait in the output register while the next request
// is taken. Shifts and table updates read each entry and write it back.
// Insert shifts the members above the slot up and then bumps the starts of
// the classes after the target. Remove searches the slots, shifts the
// members after the match down and lowers the starts past it; when the
// owner's class is closed, the start table is compacted from the owner on.
module color_class_partition_table #(
    parameter int MAX_VERTICES = ccpt_pkg::MAX_VERTICES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ccpt_pkg::CMD_W-1:0]    s_command,
    input  logic [7:0]                    s_class_number,
    input  logic [ccpt_pkg::VTX_W-1:0]    s_vertex_id,
    input  logic [7:0]                    s_slot_position,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ccpt_pkg::STAT_W-1:0]   m_status,
    output logic [ccpt_pkg::TOT_W-1:0]    m_class_total,
    output logic [ccpt_pkg::TOT_W-1:0]    m_member_total,
    output logic [7:0]                    m_found_class,
    output logic                          m_class_closed,
    output logic [ccpt_pkg::TOT_W-1:0]    m_read_value
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int WW = CW + 8;
    localparam int VW = ccpt_pkg::VTX_W;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_INS_POS = 4'd1;
    localparam logic [3:0] S_INS_SHR = 4'd2;
    localparam logic [3:0] S_INS_SHW = 4'd3;
    localparam logic [3:0] S_INS_PUT = 4'd4;
    localparam logic [3:0] S_TBL_RD  = 4'd5;
    localparam logic [3:0] S_TBL_WR  = 4'd6;
    localparam logic [3:0] S_RM_RD   = 4'd7;
    localparam logic [3:0] S_RM_CMP  = 4'd8;
    localparam logic [3:0] S_RM_SHR  = 4'd9;
    localparam logic [3:0] S_RM_SHW  = 4'd10;
    localparam logic [3:0] S_CMP_RD  = 4'd11;
    localparam logic [3:0] S_CMP_WR  = 4'd12;
    localparam logic [3:0] S_RDW     = 4'd13;
    localparam logic [3:0] S_DONE    = 4'd14;

    logic [3:0] state_reg, state_next;
    logic       rem_reg, rem_next;
    logic       rsel_reg, rsel_next;
    logic [7:0] cls_reg, cls_next;
    logic [VW-1:0] vtx_reg, vtx_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] tot_reg, tot_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] owner_reg, owner_next;
    logic [CW-1:0] ostart_reg, ostart_next;
    logic [CW-1:0] nold_reg, nold_next;
    logic       seen_reg, seen_next;
    logic       closed_reg, closed_next;
    logic [ccpt_pkg::STAT_W-1:0] st_reg, st_next;
    logic [ccpt_pkg::TOT_W-1:0]  rv_reg, rv_next;
    logic       mv_reg, mv_next;
    logic [ccpt_pkg::STAT_W-1:0] ost_reg, ost_next;
    logic [ccpt_pkg::TOT_W-1:0]  octot_reg, octot_next;
    logic [ccpt_pkg::TOT_W-1:0]  omtot_reg, omtot_next;
    logic [7:0] ofound_reg, ofound_next;
    logic       oclosed_reg, oclosed_next;
    logic [ccpt_pkg::TOT_W-1:0]  orv_reg, orv_next;

    logic          m_we;
    logic [AW-1:0] m_waddr, m_raddr;
    logic [VW-1:0] m_wdata, m_rdata;
    logic          t_we;
    logic [CW-1:0] t_waddr, t_raddr, t_wdata, t_rdata;

    logic [CW-1:0] idx_m1, idx_p1, idx_p2, pos_p1, max_c;
    logic          accept;

    assign idx_m1 = idx_reg - CW'(1);
    assign idx_p1 = idx_reg + CW'(1);
    assign idx_p2 = idx_reg + CW'(2);
    assign pos_p1 = pos_reg + CW'(1);
    assign max_c  = CW'(MAX_VERTICES);
    assign s_ready = (state_reg == S_IDLE);
    assign accept = s_valid && s_ready;

    ccpt_ram #(.DATA_W(VW), .DEPTH(MAX_VERTICES)) u_member (
        .aclk(aclk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
        .raddr(m_raddr), .rdata(m_rdata)
    );

    ccpt_ram #(.DATA_W(CW), .DEPTH(MAX_VERTICES + 1)) u_start (
        .aclk(aclk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
        .raddr(t_raddr), .rdata(t_rdata)
    );

    always_comb begin
        state_next = state_reg;
        rem_next = rem_reg;
        rsel_next = rsel_reg;
        cls_next = cls_reg;
        vtx_next = vtx_reg;
        cnt_next = cnt_reg;
        tot_next = tot_reg;
        idx_next = idx_reg;
        pos_next = pos_reg;
        owner_next = owner_reg;
        ostart_next = ostart_reg;
        nold_next = nold_reg;
        seen_next = seen_reg;
        closed_next = closed_reg;
        st_next = st_reg;
        rv_next = rv_reg;
        mv_next = mv_reg && !m_ready;
        ost_next = ost_reg;
        octot_next = octot_reg;
        omtot_next = omtot_reg;
        ofound_next = ofound_reg;
        oclosed_next = oclosed_reg;
        orv_next = orv_reg;
        m_we = 1'b0;
        m_waddr = idx_reg[AW-1:0];
        m_wdata = m_rdata;
        m_raddr = idx_reg[AW-1:0];
        t_we = 1'b0;
        t_waddr = idx_reg;
        t_wdata = t_rdata;
        t_raddr = idx_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cls_next = s_class_number;
                    vtx_next = s_vertex_id;
                    st_next = ccpt_pkg::ST_OK;
                    rv_next = '0;
                    owner_next = '0;
                    ostart_next = '0;
                    seen_next = 1'b0;
                    closed_next = 1'b0;
                    rem_next = 1'b0;
                    state_next = S_DONE;
                    unique case (s_command)
                        ccpt_pkg::CMD_INSERT: begin
                            if (WW'(s_class_number) >= WW'(cnt_reg)) begin
                                st_next = ccpt_pkg::ST_RANGE;
                            end else if (tot_reg >= max_c) begin
                                st_next = ccpt_pkg::ST_FULL;
                            end else begin
                                t_raddr = CW'(s_class_number) + CW'(1);
                                state_next = S_INS_POS;
                            end
                        end
                        ccpt_pkg::CMD_OPEN: begin
                            if (tot_reg >= max_c) begin
                                st_next = ccpt_pkg::ST_FULL;
                            end else begin
                                m_we = 1'b1;
                                m_waddr = tot_reg[AW-1:0];
                                m_wdata = s_vertex_id;
                                t_we = 1'b1;
                                t_waddr = cnt_reg + CW'(1);
                                t_wdata = tot_reg + CW'(1);
                                cnt_next = cnt_reg + CW'(1);
                                tot_next = tot_reg + CW'(1);
                            end
                        end
                        ccpt_pkg::CMD_REMOVE: begin
                            rem_next = 1'b1;
                            if (tot_reg == '0) begin
                                st_next = ccpt_pkg::ST_NOT_FOUND;
                            end else begin
                                idx_next = '0;
                                state_next = S_RM_RD;
                            end
                        end
                        ccpt_pkg::CMD_RD_MEMBER: begin
                            if (WW'(s_slot_position) >= WW'(tot_reg)) begin
                                st_next = ccpt_pkg::ST_RANGE;
                            end else begin
                                m_raddr = AW'(s_slot_position);
                                rsel_next = 1'b1;
                                state_next = S_RDW;
                            end
                        end
                        ccpt_pkg::CMD_RD_START: begin
                            if (WW'(s_class_number) > WW'(cnt_reg)) begin
                                st_next = ccpt_pkg::ST_RANGE;
                            end else if (s_class_number != 8'd0) begin
                                t_raddr = CW'(s_class_number);
                                rsel_next = 1'b0;
                                state_next = S_RDW;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_INS_POS: begin
                pos_next = t_rdata;
                idx_next = tot_reg;
                state_next = (tot_reg > t_rdata) ? S_INS_SHR : S_INS_PUT;
            end
            S_INS_SHR: begin
                m_raddr = idx_m1[AW-1:0];
                state_next = S_INS_SHW;
            end
            S_INS_SHW: begin
                m_we = 1'b1;
                idx_next = idx_m1;
                state_next = (idx_m1 == pos_reg) ? S_INS_PUT : S_INS_SHR;
            end
            S_INS_PUT: begin
                m_we = 1'b1;
                m_waddr = pos_reg[AW-1:0];
                m_wdata = vtx_reg;
                tot_next = tot_reg + CW'(1);
                idx_next = CW'(cls_reg) + CW'(1);
                state_next = S_TBL_RD;
            end
            S_TBL_RD: begin
                state_next = S_TBL_WR;
            end
            S_TBL_WR: begin
                if (!rem_reg) begin
                    t_we = 1'b1;
                    t_wdata = t_rdata + CW'(1);
                end else if (t_rdata > pos_reg) begin
                    t_we = 1'b1;
                    t_wdata = t_rdata - CW'(1);
                    if (!seen_reg) begin
                        seen_next = 1'b1;
                        nold_next = t_rdata;
                    end
                end else begin
                    owner_next = idx_reg;
                    ostart_next = t_rdata;
                end
                idx_next = idx_p1;
                state_next = S_TBL_RD;
                if (idx_reg == cnt_reg) begin
                    state_next = S_DONE;
                    if (rem_reg && ostart_reg == pos_reg &&
                        (seen_reg ? nold_reg : t_rdata) == pos_p1) begin
                        closed_next = 1'b1;
                        idx_next = owner_reg;
                        state_next = S_CMP_RD;
                    end
                end
            end
            S_RM_RD: begin
                state_next = S_RM_CMP;
            end
            S_RM_CMP: begin
                if (m_rdata == vtx_reg) begin
                    pos_next = idx_reg;
                    if (idx_p1 < tot_reg) begin
                        state_next = S_RM_SHR;
                    end else begin
                        tot_next = tot_reg - CW'(1);
                        idx_next = CW'(1);
                        state_next = S_TBL_RD;
                    end
                end else begin
                    idx_next = idx_p1;
                    if (idx_p1 == tot_reg) begin
                        st_next = ccpt_pkg::ST_NOT_FOUND;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_RM_RD;
                    end
                end
            end
            S_RM_SHR: begin
                m_raddr = idx_p1[AW-1:0];
                state_next = S_RM_SHW;
            end
            S_RM_SHW: begin
                m_we = 1'b1;
                idx_next = idx_p1;
                state_next = S_RM_SHR;
                if (idx_p2 == tot_reg) begin
                    tot_next = tot_reg - CW'(1);
                    idx_next = CW'(1);
                    state_next = S_TBL_RD;
                end
            end
            S_CMP_RD: begin
                t_raddr = idx_p1;
                state_next = S_CMP_WR;
            end
            S_CMP_WR: begin
                t_we = 1'b1;
                idx_next = idx_p1;
                state_next = S_CMP_RD;
                if (idx_p1 == cnt_reg) begin
                    cnt_next = cnt_reg - CW'(1);
                    state_next = S_DONE;
                end
            end
            S_RDW: begin
                rv_next = rsel_reg ? ccpt_pkg::TOT_W'(m_rdata) : ccpt_pkg::TOT_W'(t_rdata);
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!mv_reg || m_ready) begin
                    mv_next = 1'b1;
                    ost_next = st_reg;
                    octot_next = ccpt_pkg::TOT_W'(cnt_reg);
                    omtot_next = ccpt_pkg::TOT_W'(tot_reg);
                    ofound_next = (rem_reg && st_reg == ccpt_pkg::ST_OK) ? 8'(owner_reg) : 8'd0;
                    oclosed_next = closed_reg;
                    orv_next = rv_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            tot_reg <= '0;
            mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            tot_reg <= tot_next;
            mv_reg <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        rsel_reg <= rsel_next;
        cls_reg <= cls_next;
        vtx_reg <= vtx_next;
        idx_reg <= idx_next;
        pos_reg <= pos_next;
        owner_reg <= owner_next;
        ostart_reg <= ostart_next;
        nold_reg <= nold_next;
        seen_reg <= seen_next;
        closed_reg <= closed_next;
        st_reg <= st_next;
        rv_reg <= rv_next;
        ost_reg <= ost_next;
        octot_reg <= octot_next;
        omtot_reg <= omtot_next;
        ofound_reg <= ofound_next;
        oclosed_reg <= oclosed_next;
        orv_reg <= orv_next;
    end

    assign m_valid = mv_reg;
    assign m_status = ost_reg;
    assign m_class_total = octot_reg;
    assign m_member_total = omtot_reg;
    assign m_found_class = ofound_reg;
    assign m_class_closed = oclosed_reg;
    assign m_read_value = orv_reg;

`ifndef SYNTH
    a_tot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        tot_reg <= max_c) else $error("member count beyond capacity");
    a_cls_le_tot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (cnt_reg <= tot_reg)) else $error("empty class kept");
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready) else $error("request taken while busy");
    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && (!mv_reg || m_ready)) |=> mv_reg)
        else $error("result not presented");
`endif

endmodule
